@@ design/bldc_pkg.sv @@
// shared types and constants for the bucketed lru digest cache
package bldc_pkg;

   localparam int NUM_BUCKETS = 1024;
   localparam int WAYS        = 4;
   localparam int BUCKET_W    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef enum logic {
      REQ_LOOKUP = 1'b0,
      REQ_INSERT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK
   } state_type;

   typedef struct packed {
      logic [63:0] tag_w0;
      logic [63:0] tag_w1;
      logic [31:0] tag_w2;
      logic [63:0] data_w0;
      logic [63:0] data_w1;
      logic [31:0] data_w2;
      logic [31:0] result;
   } entry_type;

   // way 0 is the most recent entry of the bucket
   typedef entry_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic      hit;
      logic      wr_en;
      row_type   row;
      entry_type hit_entry;
   } upd_type;

endpackage

@@ design/bldc_row_ram.sv @@
// bucket row memory, one full bucket per word, registered read
module bldc_row_ram (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [bldc_pkg::BUCKET_W-1:0] rd_addr,
   output bldc_pkg::row_type            rd_data,
   input  logic                         wr_en,
   input  logic [bldc_pkg::BUCKET_W-1:0] wr_addr,
   input  bldc_pkg::row_type            wr_data
);

   bldc_pkg::row_type mem_ff [bldc_pkg::NUM_BUCKETS];
   bldc_pkg::row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bldc_row_update.sv @@
// tag compare over one bucket and the move-to-front rearrangement of its row
module bldc_row_update (
   input  bldc_pkg::row_type   row,
   input  logic                is_insert,
   input  bldc_pkg::entry_type new_entry,
   output bldc_pkg::upd_type   upd
);

   logic [bldc_pkg::WAYS-1:0]  match;
   logic [bldc_pkg::WAY_W-1:0] pos;
   logic                       any_match;
   bldc_pkg::entry_type        front;

   always_comb begin
      for (int i = 0; i < bldc_pkg::WAYS; i++) begin
         match[i] = (row[i].tag_w0 == new_entry.tag_w0) &&
                    (row[i].tag_w1 == new_entry.tag_w1) &&
                    (row[i].tag_w2 == new_entry.tag_w2);
      end
   end

   // nearest the front wins; an insert shifts the whole bucket
   always_comb begin
      pos       = bldc_pkg::WAY_W'(bldc_pkg::WAYS - 1);
      any_match = 1'b0;
      for (int i = bldc_pkg::WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            pos       = bldc_pkg::WAY_W'(i);
            any_match = 1'b1;
         end
      end
      if (is_insert) begin
         pos = bldc_pkg::WAY_W'(bldc_pkg::WAYS - 1);
      end
   end

   assign front = is_insert ? new_entry : row[pos];

   always_comb begin
      upd.hit       = any_match && !is_insert;
      upd.wr_en     = is_insert || any_match;
      upd.hit_entry = row[pos];
      upd.row[0]    = front;
      for (int i = 1; i < bldc_pkg::WAYS; i++) begin
         upd.row[i] = (bldc_pkg::WAY_W'(i) <= pos) ? row[i-1] : row[i];
      end
   end

endmodule

@@ design/bucketed_lru_digest_cache.sv @@
// top level: request capture, clearing pass, bucket read-modify-write, response register
//
//  channel | handshake             | payload
//  req     | req_valid / req_stall | req_type, req_key_w0..2, req_file_w0..2, req_result_word
//  rsp     | rsp_valid / rsp_stall | rsp_found, rsp_found_digest_w0..2, rsp_found_result_word
//
//  each request takes the bucket row read, then compare and write back; no new request is taken meanwhile.
//  after reset the row memory is zeroed, one bucket a cycle, all NUM_BUCKETS (1024) buckets;
//  req_stall stays high during that pass.
//  a new request is taken while a response waits; the write back of that request
//  holds until the response register is free.
module bucketed_lru_digest_cache (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [63:0] req_key_w0,
   input  logic [63:0] req_key_w1,
   input  logic [31:0] req_key_w2,
   input  logic [63:0] req_file_w0,
   input  logic [63:0] req_file_w1,
   input  logic [31:0] req_file_w2,
   input  logic [31:0] req_result_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [63:0] rsp_found_digest_w0,
   output logic [63:0] rsp_found_digest_w1,
   output logic [31:0] rsp_found_digest_w2,
   output logic [31:0] rsp_found_result_word
);

   bldc_pkg::state_type            state_ff, state_in;
   logic [bldc_pkg::BUCKET_W-1:0]  clr_ff, clr_in;
   logic [bldc_pkg::BUCKET_W-1:0]  req_bucket;
   logic [bldc_pkg::BUCKET_W-1:0]  bucket_ff;
   logic                           insert_ff;
   bldc_pkg::entry_type            entry_ff;
   bldc_pkg::row_type              rd_row;
   bldc_pkg::row_type              wr_row;
   logic [bldc_pkg::BUCKET_W-1:0]  wr_addr;
   logic                           wr_en;
   logic                           accept;
   logic                           out_free;
   logic                           finish;
   bldc_pkg::upd_type              upd;

   logic        rsp_valid_ff;
   logic        rsp_found_ff;
   logic [63:0] rsp_d0_ff;
   logic [63:0] rsp_d1_ff;
   logic [31:0] rsp_d2_ff;
   logic [31:0] rsp_res_ff;

   // bucket = first four key bytes modulo bucket count
   assign req_bucket = bldc_pkg::BUCKET_W'(req_key_w0[63:32] % 32'(bldc_pkg::NUM_BUCKETS));

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bldc_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      accept    = 1'b0;
      finish    = 1'b0;
      req_stall = 1'b1;
      wr_en     = 1'b0;
      wr_addr   = bucket_ff;
      wr_row    = upd.row;
      unique case (state_ff)
         bldc_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_row  = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == bldc_pkg::BUCKET_W'(bldc_pkg::NUM_BUCKETS - 1)) begin
               state_in = bldc_pkg::ST_IDLE;
            end
         end
         bldc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
            if (req_valid) begin
               state_in = bldc_pkg::ST_LOOK;
            end
         end
         bldc_pkg::ST_LOOK: begin
            if (out_free) begin
               finish   = 1'b1;
               wr_en    = upd.wr_en;
               state_in = bldc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bldc_pkg::ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bucket_ff        <= req_bucket;
         insert_ff        <= (req_type == bldc_pkg::REQ_INSERT);
         entry_ff.tag_w0  <= req_key_w0;
         entry_ff.tag_w1  <= req_key_w1;
         entry_ff.tag_w2  <= req_key_w2;
         entry_ff.data_w0 <= req_file_w0;
         entry_ff.data_w1 <= req_file_w1;
         entry_ff.data_w2 <= req_file_w2;
         entry_ff.result  <= req_result_word;
      end
   end

   bldc_row_ram u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_bucket),
      .rd_data (rd_row),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row)
   );

   bldc_row_update u_update (
      .row       (rd_row),
      .is_insert (insert_ff),
      .new_entry (entry_ff),
      .upd       (upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_found_ff <= upd.hit;
         rsp_d0_ff    <= upd.hit ? upd.hit_entry.data_w0 : '0;
         rsp_d1_ff    <= upd.hit ? upd.hit_entry.data_w1 : '0;
         rsp_d2_ff    <= upd.hit ? upd.hit_entry.data_w2 : '0;
         rsp_res_ff   <= upd.hit ? upd.hit_entry.result  : '0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_found             = rsp_found_ff;
   assign rsp_found_digest_w0   = rsp_d0_ff;
   assign rsp_found_digest_w1   = rsp_d1_ff;
   assign rsp_found_digest_w2   = rsp_d2_ff;
   assign rsp_found_result_word = rsp_res_ff;

endmodule

@@ design/bldc_checker.sv @@
// port-level checks for the bucketed lru digest cache, bound to the top level
module bldc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_found,
   input logic [63:0] rsp_found_digest_w0,
   input logic [63:0] rsp_found_digest_w1,
   input logic [31:0] rsp_found_digest_w2,
   input logic [31:0] rsp_found_result_word
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a miss or an insert carries all-zero data
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_found_digest_w0 == '0) &&
         (rsp_found_digest_w1 == '0) && (rsp_found_digest_w2 == '0) &&
         (rsp_found_result_word == '0))
      else $error("miss response with nonzero data");

   // one request in flight at a time
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in flight");

   // clearing pass blocks requests right after reset
   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request port open during clearing pass");

endmodule

bind bucketed_lru_digest_cache bldc_checker u_bldc_checker (.*);

@@ test/bucketed_lru_digest_cache_test.sv @@
// self-checking testbench for the bucketed lru digest cache
module bucketed_lru_digest_cache_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_REQS  = 1100;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOT_BUCKETS  = 12;
   localparam int POOL_DEPTH   = 48;
   localparam int PRINT_LIMIT  = 40;
   localparam int TAIL_CYCLES  = 20;

   typedef struct {
      bldc_pkg::op_type kind;
      logic [63:0]      key_w0;
      logic [63:0]      key_w1;
      logic [31:0]      key_w2;
      logic [63:0]      file_w0;
      logic [63:0]      file_w1;
      logic [31:0]      file_w2;
      logic [31:0]      result_word;
      int               gap;
      bit               drain;
   } request_type;

   typedef struct {
      logic        found;
      logic [63:0] digest_w0;
      logic [63:0] digest_w1;
      logic [31:0] digest_w2;
      logic [31:0] result_word;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = 1'b0;
   logic [63:0] req_key_w0 = '0;
   logic [63:0] req_key_w1 = '0;
   logic [31:0] req_key_w2 = '0;
   logic [63:0] req_file_w0 = '0;
   logic [63:0] req_file_w1 = '0;
   logic [31:0] req_file_w2 = '0;
   logic [31:0] req_result_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [63:0] rsp_found_digest_w0;
   logic [63:0] rsp_found_digest_w1;
   logic [31:0] rsp_found_digest_w2;
   logic [31:0] rsp_found_result_word;

   request_type         req_backlog [$];
   result_type          expected_results [$];
   bldc_pkg::entry_type shadow_cache [bldc_pkg::NUM_BUCKETS][bldc_pkg::WAYS];
   request_type         offered;
   int                  accepted_cnt = 0;
   int                  rsp_seen = 0;
   int                  fail_cnt = 0;
   int                  cycle_cnt = 0;
   logic                long_hold = 1'b0;

   bucketed_lru_digest_cache i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_type              (req_type),
      .req_key_w0            (req_key_w0),
      .req_key_w1            (req_key_w1),
      .req_key_w2            (req_key_w2),
      .req_file_w0           (req_file_w0),
      .req_file_w1           (req_file_w1),
      .req_file_w2           (req_file_w2),
      .req_result_word       (req_result_word),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_found             (rsp_found),
      .rsp_found_digest_w0   (rsp_found_digest_w0),
      .rsp_found_digest_w1   (rsp_found_digest_w1),
      .rsp_found_digest_w2   (rsp_found_digest_w2),
      .rsp_found_result_word (rsp_found_result_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // applies one request to the shadow cache and returns the response it should give
   function automatic result_type predict_cache(request_type r);
      result_type          res;
      bldc_pkg::entry_type hit;
      int                  b;
      int                  w;
      int                  j;
      res = '{default: '0};
      b = int'(r.key_w0[63:32] % 32'(bldc_pkg::NUM_BUCKETS));
      if (r.kind == bldc_pkg::REQ_INSERT) begin
         for (w = bldc_pkg::WAYS - 1; w > 0; w--) shadow_cache[b][w] = shadow_cache[b][w-1];
         hit.tag_w0  = r.key_w0;
         hit.tag_w1  = r.key_w1;
         hit.tag_w2  = r.key_w2;
         hit.data_w0 = r.file_w0;
         hit.data_w1 = r.file_w1;
         hit.data_w2 = r.file_w2;
         hit.result  = r.result_word;
         shadow_cache[b][0] = hit;
      end else begin
         // nearest way to the front wins
         for (w = 0; w < bldc_pkg::WAYS; w++) begin
            if (!res.found && shadow_cache[b][w].tag_w0 == r.key_w0 &&
                shadow_cache[b][w].tag_w1 == r.key_w1 &&
                shadow_cache[b][w].tag_w2 == r.key_w2) begin
               hit = shadow_cache[b][w];
               for (j = w; j > 0; j--) shadow_cache[b][j] = shadow_cache[b][j-1];
               shadow_cache[b][0] = hit;
               res.found       = 1'b1;
               res.digest_w0   = hit.data_w0;
               res.digest_w1   = hit.data_w1;
               res.digest_w2   = hit.data_w2;
               res.result_word = hit.result;
            end
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] rand64();
      return {32'($urandom), 32'($urandom)};
   endfunction

   // random key whose top word selects the given bucket
   function automatic logic [63:0] key_in_bucket(int bucket);
      logic [31:0] upper;
      upper = $urandom;
      upper[bldc_pkg::BUCKET_W-1:0] = bucket[bldc_pkg::BUCKET_W-1:0];
      return {upper, 32'($urandom)};
   endfunction

   function automatic request_type new_req(bldc_pkg::op_type kind, logic [63:0] k0,
                                           logic [63:0] k1, logic [31:0] k2);
      request_type r;
      r.kind        = kind;
      r.key_w0      = k0;
      r.key_w1      = k1;
      r.key_w2      = k2;
      r.file_w0     = rand64();
      r.file_w1     = rand64();
      r.file_w2     = $urandom;
      r.result_word = $urandom;
      r.gap         = 0;
      r.drain       = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      if (fail_cnt < PRINT_LIMIT)
         $display("response %0d: %s is %h, expected %h", rsp_seen, field, got, want);
      fail_cnt++;
   endtask

   always @(posedge clock) begin : req_driver
      bit holding;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         holding = req_valid;
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_cache(offered));
            accepted_cnt++;
            holding = 1'b0;
         end
         if (!holding && req_backlog.size() != 0) begin
            if (req_backlog[0].gap > 0) begin
               req_backlog[0].gap = req_backlog[0].gap - 1;
            end else if (!req_backlog[0].drain || expected_results.size() == 0) begin
               offered = req_backlog.pop_front();
               req_type        <= offered.kind;
               req_key_w0      <= offered.key_w0;
               req_key_w1      <= offered.key_w1;
               req_key_w2      <= offered.key_w2;
               req_file_w0     <= offered.file_w0;
               req_file_w1     <= offered.file_w1;
               req_file_w2     <= offered.file_w2;
               req_result_word <= offered.result_word;
               holding = 1'b1;
            end
         end
         req_valid <= holding;
      end
   end

   // one long response hold-off while requests keep coming, so the input backs up
   always @(posedge clock) begin : rsp_hold
      int hold_count;
      bit hold_done;
      if (reset) begin
         hold_count = 0;
         hold_done  = 1'b0;
         long_hold <= 1'b0;
      end else if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
         if (hold_count == HOLD_CYCLES) begin
            hold_done = 1'b1;
            long_hold <= 1'b0;
         end else begin
            hold_count++;
            long_hold <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      result_type want;
      int         stall_left;
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response, found", 64'(rsp_found), '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch("found", 64'(rsp_found), 64'(want.found));
               if (rsp_found_digest_w0 !== want.digest_w0)
                  report_mismatch("found_digest_w0", rsp_found_digest_w0, want.digest_w0);
               if (rsp_found_digest_w1 !== want.digest_w1)
                  report_mismatch("found_digest_w1", rsp_found_digest_w1, want.digest_w1);
               if (rsp_found_digest_w2 !== want.digest_w2)
                  report_mismatch("found_digest_w2", 64'(rsp_found_digest_w2),
                                  64'(want.digest_w2));
               if (rsp_found_result_word !== want.result_word)
                  report_mismatch("found_result_word", 64'(rsp_found_result_word),
                                  64'(want.result_word));
            end
            rsp_seen++;
            // every third stretch of a hundred responses runs without stalls
            stall_left = ((rsp_seen / 100) % 3 == 1) ? 0 : $urandom_range(0, 11);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= long_hold || (stall_left > 0);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      request_type r;
      request_type k;
      request_type key_pool [$];
      logic [63:0] blk [5];
      logic [63:0] hot_key;
      int          hot [HOT_BUCKETS];
      int          i;
      int          w;
      int          dice;
      for (i = 0; i < bldc_pkg::NUM_BUCKETS; i++)
         for (w = 0; w < bldc_pkg::WAYS; w++) shadow_cache[i][w] = '0;

      // untouched entries hold zeros, so the zero key hits
      req_backlog.push_back(new_req(bldc_pkg::REQ_LOOKUP, '0, '0, '0));
      req_backlog.push_back(new_req(bldc_pkg::REQ_LOOKUP, '1, '1, '1));
      r = new_req(bldc_pkg::REQ_INSERT, '1, '1, '1);
      r.file_w0 = '1;
      r.file_w1 = '1;
      r.file_w2 = '1;
      r.result_word = '1;
      req_backlog.push_back(r);
      req_backlog.push_back(new_req(bldc_pkg::REQ_LOOKUP, '1, '1, '1));
      // five inserts into one bucket push the first one out
      for (i = 0; i < 5; i++) begin
         blk[i] = key_in_bucket(5);
         req_backlog.push_back(new_req(bldc_pkg::REQ_INSERT, blk[i], 64'(i), 32'(i)));
      end
      req_backlog.push_back(new_req(bldc_pkg::REQ_LOOKUP, blk[0], 64'(0), 32'(0)));
      req_backlog.push_back(new_req(bldc_pkg::REQ_LOOKUP, blk[1], 64'(1), 32'(1)));
      req_backlog.push_back(new_req(bldc_pkg::REQ_LOOKUP, blk[4], 64'(4), 32'(4)));
      req_backlog.push_back(new_req(bldc_pkg::REQ_LOOKUP, blk[1], 64'(1), 32'(1)));
      // key equal but for the last word
      req_backlog.push_back(new_req(bldc_pkg::REQ_LOOKUP, blk[4], 64'(4), ~32'(4)));
      // duplicate insert, the newer copy must win
      blk[0] = key_in_bucket(9);
      req_backlog.push_back(new_req(bldc_pkg::REQ_INSERT, blk[0], '1, '0));
      req_backlog.push_back(new_req(bldc_pkg::REQ_INSERT, blk[0], '1, '0));
      req_backlog.push_back(new_req(bldc_pkg::REQ_LOOKUP, blk[0], '1, '0));
      r = new_req(bldc_pkg::REQ_INSERT, '0, '0, '0);
      r.file_w0 = '0;
      r.file_w1 = '0;
      r.file_w2 = '0;
      r.result_word = '0;
      req_backlog.push_back(r);
      req_backlog.push_back(new_req(bldc_pkg::REQ_LOOKUP, '0, '0, '0));

      hot[0] = 0;
      hot[1] = bldc_pkg::NUM_BUCKETS - 1;
      for (i = 2; i < HOT_BUCKETS; i++) hot[i] = $urandom_range(0, bldc_pkg::NUM_BUCKETS - 1);

      for (i = 0; i < RANDOM_REQS; i++) begin
         hot_key = key_in_bucket(hot[$urandom_range(0, HOT_BUCKETS - 1)]);
         dice = $urandom_range(0, 99);
         if (dice < 45) begin
            dice = $urandom_range(0, 3);
            if (dice < 2 || key_pool.size() == 0) begin
               r = new_req(bldc_pkg::REQ_INSERT, hot_key, rand64(), $urandom);
            end else if (dice == 2) begin
               k = key_pool[$urandom_range(0, key_pool.size() - 1)];
               r = new_req(bldc_pkg::REQ_INSERT, k.key_w0, k.key_w1, k.key_w2);
            end else begin
               r = new_req(bldc_pkg::REQ_INSERT, rand64(), rand64(), $urandom);
            end
            key_pool.push_back(r);
            if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
         end else begin
            dice = $urandom_range(0, 99);
            if (dice < 65 && key_pool.size() != 0) begin
               k = key_pool[$urandom_range(0, key_pool.size() - 1)];
               r = new_req(bldc_pkg::REQ_LOOKUP, k.key_w0, k.key_w1, k.key_w2);
            end else if (dice < 80) begin
               r = new_req(bldc_pkg::REQ_LOOKUP, hot_key, rand64(), $urandom);
            end else if (dice < 90) begin
               r = new_req(bldc_pkg::REQ_LOOKUP, rand64(), rand64(), $urandom);
            end else begin
               r = new_req(bldc_pkg::REQ_LOOKUP, '0, '0, '0);
            end
         end
         r.gap = ((i / 100) % 3 == 0) ? 0 : $urandom_range(0, 11);
         // hold the sender until the block has answered everything
         r.drain = (i == 0) || (i == 700);
         req_backlog.push_back(r);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_cnt == 0 && req_backlog.size() == 0 && !req_valid &&
          expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/bldc_pkg.sv
design/bldc_row_ram.sv
design/bldc_row_update.sv
design/bucketed_lru_digest_cache.sv
design/bldc_checker.sv
test/bucketed_lru_digest_cache_test.sv
